FILE: hdl/sam_pkg.sv
// Shared types and constants for the sorted list merge block.
package sam_pkg;

   // Element width
   localparam int DATA_W = 32;

   // Command codes on req_cmd
   localparam logic [1:0] CMD_LOAD_A = 2'd0;
   localparam logic [1:0] CMD_LOAD_B = 2'd1;
   localparam logic [1:0] CMD_MERGE  = 2'd2;

   typedef logic signed [DATA_W-1:0] elem_type;

endpackage

FILE: hdl/sam_list_mem.sv
// Single list store: one write port, one read port with registered read data.
module sam_list_mem import sam_pkg::*; #(
   parameter int AW = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  elem_type      wr_data,
   input  logic [AW-1:0] rd_addr,
   output elem_type      rd_data
);

   elem_type mem_ff [2**AW];
   elem_type rd_data_ff;

   // Write on load, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/sam_head_cmp.sv
// Head compare unit: picks the next merged element from the two list heads.
module sam_head_cmp import sam_pkg::*; (
   input  elem_type head_a,
   input  elem_type head_b,
   input  logic     a_left,
   input  logic     b_left,
   output logic     take_a,
   output elem_type sel_value
);

   // Ties go to list A; an exhausted list never wins
   always_comb begin
      take_a    = a_left && (!b_left || (head_a <= head_b));
      sel_value = take_a ? head_a : head_b;
   end

endmodule

FILE: hdl/sorted_array_merge.sv
// Two-way merge of sorted lists: top level with the merge sequencer.
//
// Usage: req_cmd selects a load into list A, a load into list B, or a merge.
// A load beat writes req_value at the tail of its list, one beat per cycle
// while idle; a full list (LIST_DEPTH elements) drops the load, flags overflow.
// A merge beat starts a run that emits every stored element in ascending
// signed order on the rsp channel, list A first on ties; rsp_last marks the
// final beat, rsp_overflow reports a dropped load since the previous merge.
// The merge beat puts the sequencer in its merge state, which registers the
// first result into the rsp output register; then one result per cycle while
// the receiver does not stall, set by the single head compare unit fed by the
// registered read ports of the two list stores. req_stall stays high for the
// whole run. A merge of two empty lists emits nothing and only clears overflow.
// The rsp output register holds its beat while rsp_stall is high; loads and
// the next merge beat are taken while the last result still waits.
// Reset (synchronous) empties both lists, clears overflow and drops any
// pending result. Store contents are not cleared; only written entries are read.
module sorted_array_merge import sam_pkg::*; #(
   parameter int LIST_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic signed [DATA_W-1:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [DATA_W-1:0] rsp_merged_value,
   output logic              rsp_last,
   output logic              rsp_overflow
);

   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(LIST_DEPTH);
   localparam logic [CW-1:0] ONE      = CW'(1);

   typedef enum logic {ST_IDLE, ST_MERGE} state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_a_ff, count_a_in;
   logic [CW-1:0] count_b_ff, count_b_in;
   logic [CW-1:0] ia_ff, ia_in;
   logic [CW-1:0] ib_ff, ib_in;
   logic          ovf_ff, ovf_in;
   logic          rsp_valid_ff, rsp_valid_in;
   elem_type      rsp_value_ff, rsp_value_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic          req_acc;
   logic          step;
   logic          a_left, b_left;
   logic          take_a;
   logic          run_done;
   logic          wr_a, wr_b;
   logic [CW-1:0] ia_nxt, ib_nxt;
   elem_type      head_a, head_b, sel_value;

   // List stores
   sam_list_mem #(.AW(AW)) u_mem_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (count_a_ff[AW-1:0]),
      .wr_data (req_value),
      .rd_addr (ia_in[AW-1:0]),
      .rd_data (head_a)
   );

   sam_list_mem #(.AW(AW)) u_mem_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (count_b_ff[AW-1:0]),
      .wr_data (req_value),
      .rd_addr (ib_in[AW-1:0]),
      .rd_data (head_b)
   );

   // Shared compare of the heads
   sam_head_cmp u_cmp (
      .head_a    (head_a),
      .head_b    (head_b),
      .a_left    (a_left),
      .b_left    (b_left),
      .take_a    (take_a),
      .sel_value (sel_value)
   );

   // Handshake and load decode
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && (state_ff == ST_IDLE);
   assign step      = (state_ff == ST_MERGE) && (!rsp_valid_ff || !rsp_stall);
   assign a_left    = (ia_ff < count_a_ff);
   assign b_left    = (ib_ff < count_b_ff);
   assign wr_a      = req_acc && (req_cmd == CMD_LOAD_A) && (count_a_ff < FULL_CNT);
   assign wr_b      = req_acc && (req_cmd == CMD_LOAD_B) && (count_b_ff < FULL_CNT);

   // Head indices after this pop, and end of run
   assign ia_nxt   = ia_ff + ((step && take_a)  ? ONE : '0);
   assign ib_nxt   = ib_ff + ((step && !take_a) ? ONE : '0);
   assign run_done = step && (ia_nxt >= count_a_ff) && (ib_nxt >= count_b_ff);

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      ovf_in       = ovf_ff;
      ia_in        = ia_nxt;
      ib_in        = ib_nxt;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_cmd)
                  CMD_LOAD_A: begin
                     if (wr_a) count_a_in = count_a_ff + ONE;
                     else      ovf_in     = 1'b1;
                  end
                  CMD_LOAD_B: begin
                     if (wr_b) count_b_in = count_b_ff + ONE;
                     else      ovf_in     = 1'b1;
                  end
                  CMD_MERGE: begin
                     if ((count_a_ff == '0) && (count_b_ff == '0)) ovf_in = 1'b0;
                     else state_in = ST_MERGE;
                  end
                  default: ;
               endcase
            end
         end
         ST_MERGE: begin
            if (step) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = sel_value;
               rsp_last_in  = run_done;
               rsp_ovf_in   = ovf_ff;
            end
            if (run_done) begin
               state_in   = ST_IDLE;
               count_a_in = '0;
               count_b_in = '0;
               ovf_in     = 1'b0;
               ia_in      = '0;
               ib_in      = '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule

FILE: hdl/sam_checker.sv
// Port-level checker for the sorted list merge block, with its bind.
module sam_checker import sam_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic signed [DATA_W-1:0] rsp_merged_value,
   input logic              rsp_last,
   input logic              rsp_overflow
);

   // Reset drops any pending result
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_merged_value)
         && $stable(rsp_last) && $stable(rsp_overflow))
      else $error("stalled result beat changed");

   // Inside a run, the next beat follows at once with the same overflow flag
   a_run_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid
         && (rsp_overflow == $past(rsp_overflow)))
      else $error("merge run broke or overflow changed mid-run");

   // No input beat is taken while a run is still being emitted
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input not stalled during merge run");

endmodule

bind sorted_array_merge sam_checker u_sam_checker (.*);

FILE: bench/tb_sorted_array_merge.sv
// Self-checking testbench for sorted_array_merge: list loads, merges, overflow, random traffic.
`timescale 1ns / 100ps

module tb_sorted_array_merge;
   import sam_pkg::*;

   localparam int DEPTH      = 32;
   localparam int RAND_ITEMS = 75;
   localparam int PRED       = -1;       // row result comes from the merge predictor
   localparam int TAIL_CYC   = 16;
   localparam logic [1:0] CMD_NOP = 2'd3; // unused command code
   localparam elem_type ELEM_MIN = 32'sh8000_0000;
   localparam elem_type ELEM_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      elem_type value;
      logic     last;
      logic     ovf;
   } merge_beat_type;

   typedef struct {
      logic [1:0] cmd;
      elem_type   value;
      int         reps;      // repeated loads use value, value+1, ...
      int         n_typed;   // typed-in result count, or PRED
      elem_type   t0;
      elem_type   t1;
      logic       t_ovf;
   } stim_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   logic [1:0]      req_cmd = CMD_LOAD_A;
   elem_type        req_value = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   elem_type        rsp_merged_value;
   logic            rsp_last;
   logic            rsp_overflow;

   // predictor state
   elem_type        list_a [$];
   elem_type        list_b [$];
   logic            ovf_seen = 1'b0;
   merge_beat_type  merge_expect_q [$];

   int              mismatches = 0;
   logic            calm = 1'b0;   // no idling on either side while set

   // directed stimulus
   stim_row_type dir_rows [28] = '{
      '{CMD_MERGE,  32'sd0,        1,  0,    ELEM_MIN, ELEM_MIN, 1'b0}, // empty lists after reset
      '{CMD_LOAD_A, ELEM_MIN,      1,  PRED, 0, 0, 1'b0},
      '{CMD_LOAD_B, ELEM_MAX,      1,  PRED, 0, 0, 1'b0},
      '{CMD_MERGE,  32'sd0,        1,  2,    ELEM_MIN, ELEM_MAX, 1'b0},
      '{CMD_NOP,    32'sh5A5A_A5A5, 1, PRED, 0, 0, 1'b0},
      '{CMD_LOAD_B, ELEM_MAX,      1,  PRED, 0, 0, 1'b0},
      '{CMD_MERGE,  -32'sd1,       1,  1,    ELEM_MAX, 0, 1'b0},        // value ignored
      '{CMD_LOAD_B, -32'sd1,       1,  PRED, 0, 0, 1'b0},               // ties
      '{CMD_LOAD_A, -32'sd1,       1,  PRED, 0, 0, 1'b0},
      '{CMD_LOAD_A, 32'sd0,        1,  PRED, 0, 0, 1'b0},
      '{CMD_LOAD_B, 32'sd0,        1,  PRED, 0, 0, 1'b0},
      '{CMD_MERGE,  32'sd0,        1,  PRED, 0, 0, 1'b0},
      '{CMD_LOAD_B, 32'sd1,        3,  PRED, 0, 0, 1'b0},               // list B only
      '{CMD_MERGE,  32'sd0,        1,  PRED, 0, 0, 1'b0},
      '{CMD_LOAD_A, 32'sd10,       3,  PRED, 0, 0, 1'b0},               // B tail after A runs out
      '{CMD_LOAD_B, -32'sd5,       1,  PRED, 0, 0, 1'b0},
      '{CMD_LOAD_B, 32'sd20,       1,  PRED, 0, 0, 1'b0},
      '{CMD_MERGE,  32'sd0,        1,  PRED, 0, 0, 1'b0},
      '{CMD_LOAD_A, 32'sd100,      1,  PRED, 0, 0, 1'b0},               // unsorted list A
      '{CMD_LOAD_A, -32'sd100,     1,  PRED, 0, 0, 1'b0},
      '{CMD_LOAD_B, 32'sd0,        1,  PRED, 0, 0, 1'b0},
      '{CMD_MERGE,  32'sd0,        1,  PRED, 0, 0, 1'b0},
      '{CMD_LOAD_A, -32'sd1000,    34, PRED, 0, 0, 1'b0},               // both lists overflow
      '{CMD_LOAD_B, ELEM_MIN,      33, PRED, 0, 0, 1'b0},
      '{CMD_MERGE,  32'sd0,        1,  PRED, 0, 0, 1'b0},
      '{CMD_LOAD_A, 32'sd7,        1,  PRED, 0, 0, 1'b0},
      '{CMD_MERGE,  32'sd0,        1,  1,    32'sd7, 0, 1'b0},          // overflow flag cleared
      '{CMD_MERGE,  32'sd0,        1,  0,    0, 0, 1'b0}
   };

   sorted_array_merge #(.LIST_DEPTH(DEPTH)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_merged_value (rsp_merged_value),
      .rsp_last         (rsp_last),
      .rsp_overflow     (rsp_overflow)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // idle with a chance of 32 in a hundred, never while calm
   function automatic bit idle_roll();
      return !calm && ($urandom_range(0, 99) < 32);
   endfunction

   function automatic elem_type rand_elem();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return ELEM_MIN;
      if (pick < 10) return ELEM_MAX;
      if (pick < 40) return elem_type'(int'($urandom_range(0, 16)) - 8);
      return elem_type'($urandom);
   endfunction

   // mostly short lists, now and then empty or at or past the depth
   function automatic int pick_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) return DEPTH + int'($urandom_range(0, 3));
      if (r < 15) return 0;
      return int'($urandom_range(1, 8));
   endfunction

   // merge predictor: loads append or flag overflow, a merge drains both lists
   function automatic void merge_model(input logic [1:0] cmd, input elem_type val,
                                       input bit keep);
      int             ia;
      int             ib;
      int             total;
      merge_beat_type beat;
      ia = 0;
      ib = 0;
      case (cmd)
         CMD_LOAD_A: begin
            if (list_a.size() < DEPTH) list_a.push_back(val);
            else ovf_seen = 1'b1;
         end
         CMD_LOAD_B: begin
            if (list_b.size() < DEPTH) list_b.push_back(val);
            else ovf_seen = 1'b1;
         end
         CMD_MERGE: begin
            total = list_a.size() + list_b.size();
            for (int k = 0; k < total; k++) begin
               // ties take list A's head
               if (ia < list_a.size() && (ib >= list_b.size() || list_a[ia] <= list_b[ib])) begin
                  beat.value = list_a[ia];
                  ia++;
               end else begin
                  beat.value = list_b[ib];
                  ib++;
               end
               beat.last = (k == total - 1);
               beat.ovf  = ovf_seen;
               if (keep) merge_expect_q.push_back(beat);
            end
            list_a.delete();
            list_b.delete();
            ovf_seen = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // one request beat: optional idle gap, then hold until taken
   task automatic run_item(input logic [1:0] cmd, input elem_type val, input bit keep);
      if (idle_roll()) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (idle_roll());
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= val;
      do @(posedge clock); while (req_stall);
      merge_model(cmd, val, keep);
   endtask

   task automatic note_mismatch(input string what, input merge_beat_type exp);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t mismatch (%s): exp %0d/%0b/%0b got %0d/%0b/%0b",
                  $realtime, what, exp.value, exp.last, exp.ovf,
                  rsp_merged_value, rsp_last, rsp_overflow);
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_stall <= idle_roll();
   end

   // result checker
   always @(posedge clock) begin
      merge_beat_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (merge_expect_q.size() == 0) begin
            exp = '0;
            note_mismatch("unexpected beat", exp);
         end else begin
            exp = merge_expect_q.pop_front();
            if (rsp_merged_value !== exp.value || rsp_last !== exp.last ||
                rsp_overflow !== exp.ovf)
               note_mismatch("field", exp);
         end
      end
   end

   // stimulus
   initial begin
      elem_type       qa [$];
      elem_type       qb [$];
      merge_beat_type beat;
      int             na;
      int             nb;
      int             ia;
      int             ib;
      int             rand_items;
      bit             keep;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed rows, typed-in results where obvious
      foreach (dir_rows[r]) begin
         keep = (dir_rows[r].n_typed == PRED);
         for (int k = 0; k < dir_rows[r].reps; k++)
            run_item(dir_rows[r].cmd, dir_rows[r].value + elem_type'(k), keep);
         for (int k = 0; k < dir_rows[r].n_typed; k++) begin
            beat.value = (k == 0) ? dir_rows[r].t0 : dir_rows[r].t1;
            beat.last  = (k == dir_rows[r].n_typed - 1);
            beat.ovf   = dir_rows[r].t_ovf;
            merge_expect_q.push_back(beat);
         end
      end

      // random well-formed load sequences closed by a merge, with some noise
      rand_items = 0;
      while (rand_items < RAND_ITEMS) begin
         calm = (rand_items >= 25 && rand_items < 60);
         na = pick_len();
         nb = pick_len();
         qa.delete();
         qb.delete();
         for (int k = 0; k < na; k++) qa.push_back(rand_elem());
         for (int k = 0; k < nb; k++) qb.push_back(rand_elem());
         if ($urandom_range(0, 9) != 0) qa.sort();
         if ($urandom_range(0, 9) != 0) qb.sort();
         ia = 0;
         ib = 0;
         while (ia < na || ib < nb) begin
            if ($urandom_range(0, 19) == 0)
               run_item(CMD_NOP, elem_type'($urandom), 1'b1);
            if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
               run_item(CMD_LOAD_A, qa[ia], 1'b1);
               ia++;
            end else begin
               run_item(CMD_LOAD_B, qb[ib], 1'b1);
               ib++;
            end
            rand_items++;
         end
         run_item(CMD_MERGE, elem_type'($urandom), 1'b1);
         rand_items++;
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // drain
      while (merge_expect_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYC) @(posedge clock);

      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/sam_pkg.sv
hdl/sam_list_mem.sv
hdl/sam_head_cmp.sv
hdl/sorted_array_merge.sv
hdl/sam_checker.sv
bench/tb_sorted_array_merge.sv
